>>> rtl/ivalloc_pkg.sv
`timescale 1ns / 1ps
package ivalloc_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned VEC_W    = 8;
  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned STATUS_W = 2;

  // free-vector search works on groups of this many bitmap entries
  localparam int unsigned GROUP_W  = 16;
  localparam int unsigned BIT_W    = $clog2(GROUP_W);

  typedef enum logic [CMD_W-1:0] {
    CMD_REGISTER   = 2'd0,
    CMD_UNREGISTER = 2'd1,
    CMD_ALLOCATE   = 2'd2,
    CMD_LOOKUP     = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_NO_SPACE = 2'd2
  } status_e;

endpackage

>>> rtl/interrupt_vector_allocator.sv
`timescale 1ns / 1ps
// channel   direction  handshake                   payload
// request   in         in_valid_i / in_stall_o     command_i, vector_i, handler_address_i
// result    out        out_valid_o / out_stall_i   status_o, vector_out_o, handler_out_o
//
// one request at a time: register, unregister and lookup go through S_EXEC, S_DONE; allocate
// adds S_GROUP (group search of the free bitmap), then S_BIT (bit search in the group), and
// skips S_BIT if none is free, both if the handler is zero; lookup reads a registered port
// reset clears the in-use bitmap at once; a vector not in use reads as zero, so the memory
// needs no clearing pass and requests are taken right after reset; a stalled result sits in
// the output register and the next request is taken once the current result has moved in
module interrupt_vector_allocator #(
  parameter int unsigned VECTOR_COUNT        = 256,
  parameter int unsigned FIRST_USABLE_VECTOR = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [ivalloc_pkg::CMD_W-1:0]       command_i,
  input  logic [ivalloc_pkg::VEC_W-1:0]       vector_i,
  input  logic [ivalloc_pkg::ADDR_W-1:0]      handler_address_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ivalloc_pkg::STATUS_W-1:0]    status_o,
  output logic [ivalloc_pkg::VEC_W-1:0]       vector_out_o,
  output logic [ivalloc_pkg::ADDR_W-1:0]      handler_out_o
);

  localparam int unsigned VIDX_W     = $clog2(VECTOR_COUNT);
  localparam int unsigned NUM_GROUPS = (VECTOR_COUNT + ivalloc_pkg::GROUP_W - 1)
                                       / ivalloc_pkg::GROUP_W;
  localparam int unsigned GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int unsigned PAD_W      = NUM_GROUPS * ivalloc_pkg::GROUP_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_GROUP = 6'b000100,
    S_BIT   = 6'b001000,
    S_DONE  = 6'b010000,
    S_SPARE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // latched request
  ivalloc_pkg::cmd_e               cmd_q;
  logic [ivalloc_pkg::VEC_W-1:0]   vec_q;
  logic [ivalloc_pkg::ADDR_W-1:0]  addr_q;

  // pending result
  ivalloc_pkg::status_e            res_status_q, res_status_d;
  logic [ivalloc_pkg::VEC_W-1:0]   res_vec_q, res_vec_d;
  logic                            hit_q, hit_d;

  // output register
  logic                            out_valid_q;
  logic [ivalloc_pkg::STATUS_W-1:0] out_status_q;
  logic [ivalloc_pkg::VEC_W-1:0]   out_vec_q;
  logic [ivalloc_pkg::ADDR_W-1:0]  out_handler_q;

  // in-use bitmap, one flop per vector; set on storing a nonzero handler, cleared by unregister
  logic [VECTOR_COUNT-1:0]         used_q;
  logic [PAD_W-1:0]                free_pad;
  logic [NUM_GROUPS-1:0]           group_free_d, group_free_q;
  logic [GRP_W-1:0]                grp_q, grp_sel;
  logic                            grp_found;
  logic [ivalloc_pkg::GROUP_W-1:0] grp_bits;
  logic [ivalloc_pkg::BIT_W-1:0]   bit_sel;
  logic [VIDX_W-1:0]               found_idx;

  // handler memory
  logic [ivalloc_pkg::ADDR_W-1:0]  mem_q [VECTOR_COUNT];
  logic [ivalloc_pkg::ADDR_W-1:0]  rd_data_q;
  logic                            mem_we;
  logic [VIDX_W-1:0]               mem_waddr;
  logic                            used_set, used_clr;
  logic [VIDX_W-1:0]               used_idx;

  logic                            accept_in;
  logic                            out_free;
  logic                            vec_exists, vec_usable;
  logic [VIDX_W-1:0]               vec_idx;

  assign accept_in = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  assign vec_exists = {1'b0, vec_q} < (ivalloc_pkg::VEC_W + 1)'(VECTOR_COUNT);
  assign vec_usable = vec_exists && (vec_q >= ivalloc_pkg::VEC_W'(FIRST_USABLE_VECTOR));
  assign vec_idx    = vec_q[VIDX_W-1:0];

  // free vectors that may be allocated, padded out to whole groups
  for (genvar i = 0; i < PAD_W; i++) begin : g_free
    if (i < VECTOR_COUNT && i >= FIRST_USABLE_VECTOR) begin : g_live
      assign free_pad[i] = ~used_q[i];
    end else begin : g_dead
      assign free_pad[i] = 1'b0;
    end
  end

  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
    assign group_free_d[g] = |free_pad[g*ivalloc_pkg::GROUP_W +: ivalloc_pkg::GROUP_W];
  end

  // lowest group with a free vector
  always_comb begin
    grp_found = 1'b0;
    grp_sel   = '0;
    for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
      if (group_free_q[g]) begin
        grp_found = 1'b1;
        grp_sel   = GRP_W'(g);
      end
    end
  end

  assign grp_bits = free_pad[grp_q * ivalloc_pkg::GROUP_W +: ivalloc_pkg::GROUP_W];

  // lowest free vector inside the chosen group
  always_comb begin
    bit_sel = '0;
    for (int b = ivalloc_pkg::GROUP_W - 1; b >= 0; b--) begin
      if (grp_bits[b]) begin
        bit_sel = ivalloc_pkg::BIT_W'(b);
      end
    end
  end

  assign found_idx = VIDX_W'({grp_q, bit_sel});

  always_comb begin
    state_d      = state_q;
    res_status_d = res_status_q;
    res_vec_d    = res_vec_q;
    hit_d        = hit_q;
    mem_we       = 1'b0;
    mem_waddr    = vec_idx;
    used_set     = 1'b0;
    used_clr     = 1'b0;
    used_idx     = vec_idx;
    case (state_q)
      S_IDLE: begin
        if (accept_in) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_status_d = ivalloc_pkg::ST_OK;
        res_vec_d    = '0;
        hit_d        = 1'b0;
        state_d      = S_DONE;
        case (cmd_q)
          ivalloc_pkg::CMD_REGISTER: begin
            if (!vec_usable || addr_q == '0) begin
              res_status_d = ivalloc_pkg::ST_INVALID;
            end else begin
              mem_we   = 1'b1;
              used_set = 1'b1;
            end
          end
          ivalloc_pkg::CMD_UNREGISTER: begin
            if (!vec_usable) begin
              res_status_d = ivalloc_pkg::ST_INVALID;
            end else begin
              used_clr = 1'b1;
            end
          end
          ivalloc_pkg::CMD_ALLOCATE: begin
            if (addr_q == '0) begin
              res_status_d = ivalloc_pkg::ST_INVALID;
            end else begin
              state_d = S_GROUP;
            end
          end
          ivalloc_pkg::CMD_LOOKUP: begin
            if (!vec_exists) begin
              res_status_d = ivalloc_pkg::ST_INVALID;
            end else begin
              hit_d = used_q[vec_idx];
            end
          end
          default: begin
            res_status_d = ivalloc_pkg::ST_INVALID;
          end
        endcase
      end
      S_GROUP: begin
        if (grp_found) begin
          state_d = S_BIT;
        end else begin
          res_status_d = ivalloc_pkg::ST_NO_SPACE;
          state_d      = S_DONE;
        end
      end
      S_BIT: begin
        mem_we    = 1'b1;
        mem_waddr = found_idx;
        used_set  = 1'b1;
        used_idx  = found_idx;
        res_vec_d = ivalloc_pkg::VEC_W'(found_idx);
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      used_q       <= '0;
      out_valid_q  <= 1'b0;
      res_status_q <= ivalloc_pkg::ST_OK;
      res_vec_q    <= '0;
      hit_q        <= 1'b0;
    end else begin
      state_q      <= state_d;
      res_status_q <= res_status_d;
      res_vec_q    <= res_vec_d;
      hit_q        <= hit_d;
      if (used_set) begin
        used_q[used_idx] <= 1'b1;
      end else if (used_clr) begin
        used_q[used_idx] <= 1'b0;
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      cmd_q  <= ivalloc_pkg::cmd_e'(command_i);
      vec_q  <= vector_i;
      addr_q <= handler_address_i;
    end
    if (state_q == S_EXEC) begin
      group_free_q <= group_free_d;
    end
    if (state_q == S_GROUP) begin
      grp_q <= grp_sel;
    end
    if (state_q == S_DONE && out_free) begin
      out_status_q  <= res_status_q;
      out_vec_q     <= res_vec_q;
      out_handler_q <= hit_q ? rd_data_q : '0;
    end
  end

  // handler memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= addr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC) begin
      rd_data_q <= mem_q[vec_idx];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign vector_out_o  = out_vec_q;
  assign handler_out_o = out_handler_q;

endmodule
